/* rtl/core/scld_pkg.sv */
`default_nettype none

package scld_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned SUM_W      = 18;
    localparam int unsigned WIN_W      = 24;
    localparam int unsigned FILL_W     = 2;
    localparam int unsigned WIDX_W     = 2;
    localparam int unsigned WEIGHT_W   = 3;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned TUSER_W    = 1 + STATUS_W;

    localparam int unsigned MAX_FRAME_LEN_DEF = 127;

    localparam logic [BYTE_W-1:0] SYNC_S = 8'h53;
    localparam logic [BYTE_W-1:0] SYNC_C = 8'h43;
    localparam logic [BYTE_W-1:0] SYNC_R = 8'h52;
    localparam logic [BYTE_W-1:0] SYNC_T = 8'h54;
    localparam logic [WIN_W-1:0]  SYNC_HEAD = {SYNC_S, SYNC_C, SYNC_R};
    localparam logic [FILL_W-1:0] FILL_FULL = 2'd3;

    localparam logic [BYTE_W-1:0]   MOD_BASE     = 8'd255;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FIRST = 3'd4;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_TYPE = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_BAD_LEN = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_type;
        logic              frame_end;
        t_status           status;
    } t_result;

    // Weights cycle 4,1,2,3 over the frame byte position.
    function automatic logic [WEIGHT_W-1:0] weight_of(input logic [WIDX_W-1:0] idx);
        weight_of = (idx == '0) ? WEIGHT_FIRST : WEIGHT_W'(idx);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/scld_in_skid.sv */
`default_nettype none

module scld_in_skid (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [scld_pkg::BYTE_W-1:0]  i_s_tdata,
    output scld_pkg::t_item                   o_item,
    input  wire logic                         i_pop
);
    import scld_pkg::*;

    logic              r_main_valid;
    logic [BYTE_W-1:0] r_main_data;
    logic              r_skid_valid;
    logic [BYTE_W-1:0] r_skid_data;
    logic              accept;

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && !r_skid_valid;
    assign o_item     = '{valid: r_main_valid, data: r_main_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_pop) begin
            if (r_skid_valid) begin
                // advance the parked transfer into the main slot
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= accept;
            end
        end else if (accept) begin
            if (!r_main_valid) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (r_skid_valid) begin
                r_main_data <= r_skid_data;
            end else if (accept) begin
                r_main_data <= i_s_tdata;
            end
        end else if (accept) begin
            if (!r_main_valid) begin
                r_main_data <= i_s_tdata;
            end else begin
                r_skid_data <= i_s_tdata;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/scld_step.sv */
`default_nettype none

module scld_step #(
    parameter int unsigned MAX_FRAME_LEN = scld_pkg::MAX_FRAME_LEN_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire scld_pkg::t_item   i_item,
    input  wire logic              i_out_ready,
    output logic                   o_pop,
    output logic                   o_res_valid,
    output scld_pkg::t_result      o_result
);
    import scld_pkg::*;

    t_phase                    r_phase, n_phase;
    logic [WIN_W-1:0]          r_window, n_window;
    logic [FILL_W-1:0]         r_fill, n_fill;
    logic [LEN_W-1:0]          r_left, n_left;
    logic [WIDX_W-1:0]         r_widx, n_widx;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [BYTE_W-1:0]         r_res, n_res;

    logic [BYTE_W-1:0]         rx;
    logic                      has_result;
    logic                      advance;
    logic                      sync_hit;
    logic                      len_bad;
    logic [WEIGHT_W-1:0]       w;
    logic signed [10:0]        prod_s;
    logic [BYTE_W-1:0]         sv_mod;
    logic [9:0]                prod_m;
    logic [10:0]               res_acc;
    logic [8:0]                res_fold;
    logic [BYTE_W-1:0]         res_step;
    logic [BYTE_W-1:0]         expect_byte;
    t_result                   result;

    assign rx       = i_item.data;
    assign sync_hit = (r_fill == FILL_FULL) && (r_window == SYNC_HEAD) && (rx == SYNC_T);
    assign len_bad  = (rx == '0) || (rx > BYTE_W'(MAX_FRAME_LEN));
    assign w        = weight_of(r_widx);

    // signed weighted term for the full sum, sign kept for the remainder
    assign prod_s = $signed({{3{rx[7]}}, rx}) * $signed({8'd0, w});

    // residue mod 255 kept in 0..254; a negative byte maps to byte - 1
    assign sv_mod   = rx[7] ? (rx - 8'd1) : rx;
    assign prod_m   = 10'(sv_mod) * 10'(w);
    assign res_acc  = 11'(r_res) + 11'(prod_m);
    assign res_fold = 9'(res_acc[10:8]) + 9'(res_acc[7:0]);
    assign res_step = (res_fold >= 9'(MOD_BASE)) ? 8'(res_fold - 9'(MOD_BASE))
                                                  : res_fold[7:0];

    // low8(255 - truncating remainder): negative sums shift by 255
    assign expect_byte = (r_sum[SUM_W-1] && (r_res != '0)) ? (MOD_BASE - 8'd1 - r_res)
                                                            : (MOD_BASE - r_res);

    always_comb begin
        case (r_phase)
            PH_HUNT: has_result = 1'b0;
            PH_LEN:  has_result = len_bad;
            PH_TYPE: has_result = 1'b1;
            PH_BODY: has_result = 1'b1;
            default: has_result = 1'b0;
        endcase
    end

    assign advance     = i_item.valid && (!has_result || i_out_ready);
    assign o_pop       = advance;
    assign o_res_valid = advance && has_result;
    assign o_result    = result;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_window = r_window;
        n_fill   = r_fill;
        n_left   = r_left;
        n_widx   = r_widx;
        n_sum    = r_sum;
        n_res    = r_res;
        if (advance) begin
            case (r_phase)
                PH_HUNT: begin
                    if (sync_hit) begin
                        n_phase  = PH_LEN;
                        n_window = '0;
                        n_fill   = '0;
                    end else begin
                        n_window = {r_window[WIN_W-BYTE_W-1:0], rx};
                        if (r_fill != FILL_FULL) begin
                            n_fill = r_fill + 2'd1;
                        end
                    end
                end
                PH_LEN: begin
                    if (len_bad) begin
                        n_phase  = PH_HUNT;
                        n_window = '0;
                        n_fill   = '0;
                        n_left   = '0;
                    end else begin
                        n_phase = PH_TYPE;
                        n_left  = rx[LEN_W-1:0];
                    end
                    n_widx = '0;
                    n_sum  = '0;
                    n_res  = '0;
                end
                PH_TYPE, PH_BODY: begin
                    if (r_left <= LEN_W'(1)) begin
                        // check byte closes the frame; drop back to hunting
                        n_phase  = PH_HUNT;
                        n_window = '0;
                        n_fill   = '0;
                        n_left   = '0;
                        n_widx   = '0;
                        n_sum    = '0;
                        n_res    = '0;
                    end else begin
                        n_phase = PH_BODY;
                        n_left  = r_left - LEN_W'(1);
                        n_widx  = r_widx + 2'd1;
                        n_sum   = r_sum + SUM_W'(prod_s);
                        n_res   = res_step;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // result
    always_comb begin
        result = '{out_byte: '0, is_type: 1'b0, frame_end: 1'b0, status: ST_GOOD};
        case (r_phase)
            PH_LEN: begin
                result.frame_end = 1'b1;
                result.status    = ST_BAD_LEN;
            end
            PH_TYPE, PH_BODY: begin
                result.out_byte = rx;
                if (r_left <= LEN_W'(1)) begin
                    result.frame_end = 1'b1;
                    result.status    = (rx == expect_byte) ? ST_GOOD : ST_BAD_SUM;
                end else begin
                    result.is_type = (r_phase == PH_TYPE);
                end
            end
            default: begin
                result.out_byte = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_window <= '0;
            r_fill   <= '0;
            r_left   <= '0;
            r_widx   <= '0;
            r_sum    <= '0;
            r_res    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_fill   <= n_fill;
            r_left   <= n_left;
            r_widx   <= n_widx;
            r_sum    <= n_sum;
            r_res    <= n_res;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/scld_out_reg.sv */
`default_nettype none

module scld_out_reg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire scld_pkg::t_result             i_result,
    output logic                               o_ready,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [scld_pkg::BYTE_W-1:0]        o_m_tdata,
    output logic                               o_m_tlast,
    output logic [scld_pkg::TUSER_W-1:0]       o_m_tuser
);
    import scld_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready    = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_result.out_byte;
    assign o_m_tlast  = r_result.frame_end;
    assign o_m_tuser  = {r_result.status, r_result.is_type};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sync_length_checksum_deframer_top.sv */
// An accepted byte is held in the input register; its result is then held in the
// result register, which drives the master side.
// Throughput: one byte per cycle while the master side does not stall.
// Synchronous active-low reset clears the hunt state, the sync window and
// the input and output stream registers; the block accepts bytes in the first cycle after.
`default_nettype none

module sync_length_checksum_deframer_top #(
    parameter int unsigned MAX_FRAME_LEN = scld_pkg::MAX_FRAME_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [scld_pkg::BYTE_W-1:0]   i_s_tdata,   // [7:0] rx_byte
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [scld_pkg::BYTE_W-1:0]        o_m_tdata,   // [7:0] out_byte
    output logic                               o_m_tlast,   // frame_end
    output logic [scld_pkg::TUSER_W-1:0]       o_m_tuser    // [0] is_type, [2:1] status
);
    import scld_pkg::*;

    t_item   item;
    t_result result;
    logic    pop;
    logic    res_valid;
    logic    out_ready;

    scld_in_skid u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_item     (item),
        .i_pop      (pop)
    );

    scld_step #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_out_ready (out_ready),
        .o_pop       (pop),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    scld_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_result   (result),
        .o_ready    (out_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/scld_checker.sv */
`default_nettype none

module scld_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [scld_pkg::BYTE_W-1:0]   o_m_tdata,
    input wire logic                          o_m_tlast,
    input wire logic [scld_pkg::TUSER_W-1:0]  o_m_tuser
);
    import scld_pkg::*;

    // status is only ever good, checksum mismatch or bad length
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[2:1] == ST_GOOD || o_m_tuser[2:1] == ST_BAD_SUM
                        || o_m_tuser[2:1] == ST_BAD_LEN))
        else $error("scld: invalid status code");

    // forwarded bytes carry a zero status
    a_body_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tuser[2:1] == ST_GOOD))
        else $error("scld: status on a forwarded byte");

    // the type byte never closes a frame
    a_type_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> !o_m_tlast)
        else $error("scld: type byte flagged as frame end");

    // a bad-length status carries a zero byte
    a_bad_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast && o_m_tuser[2:1] == ST_BAD_LEN) |-> (o_m_tdata == '0))
        else $error("scld: bad-length status with nonzero byte");

    // a stalled transfer holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("scld: output transfer changed while stalled");

endmodule

bind sync_length_checksum_deframer_top scld_checker u_scld_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

/* tb/sync_length_checksum_deframer_top_tb.sv */
`timescale 1ns / 1ps

module sync_length_checksum_deframer_top_tb;
    import scld_pkg::*;

    // Tracks the deframer state and holds the frame outputs still owed by the block.
    class deframe_scoreboard;
        t_result             owed_q[$];
        logic [WIN_W-1:0]    win;
        logic [FILL_W-1:0]   fill;
        t_phase              phase;
        logic [LEN_W-1:0]    left;
        logic [WIDX_W-1:0]   widx;
        logic signed [SUM_W-1:0] wsum;
        int                  errors;

        function new();
            errors = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            win   = '0;
            fill  = '0;
            phase = PH_HUNT;
            left  = '0;
            widx  = '0;
            wsum  = '0;
        endfunction

        static function int weight_at(logic [WIDX_W-1:0] idx);
            return (idx == '0) ? 4 : int'(idx);
        endfunction

        // Check byte is low8(255 - (sum rem 255)), remainder truncated toward zero.
        static function logic [BYTE_W-1:0] check_of(logic signed [SUM_W-1:0] s);
            int r;
            r = int'(s) % 255;
            return 8'(255 - r);
        endfunction

        function void note_rx_byte(logic [BYTE_W-1:0] b);
            t_result r;
            int      sv;
            r = '0;
            case (phase)
                PH_HUNT: begin
                    if (fill == FILL_FULL && win == SYNC_HEAD && b == SYNC_T) begin
                        phase = PH_LEN;
                        win   = '0;
                        fill  = '0;
                    end else begin
                        win = {win[WIN_W-BYTE_W-1:0], b};
                        if (fill != FILL_FULL)
                            fill = fill + 1'b1;
                    end
                end
                PH_LEN: begin
                    if (b == 0 || b > MAX_FRAME_LEN_DEF) begin
                        r.frame_end = 1'b1;
                        r.status    = ST_BAD_LEN;
                        owed_q = {owed_q, r};
                        restart_hunt();
                    end else begin
                        left  = b[LEN_W-1:0];
                        widx  = '0;
                        wsum  = '0;
                        phase = PH_TYPE;
                    end
                end
                default: begin
                    if (left <= 1) begin
                        r.out_byte  = b;
                        r.frame_end = 1'b1;
                        r.status    = (b == check_of(wsum)) ? ST_GOOD : ST_BAD_SUM;
                        owed_q = {owed_q, r};
                        restart_hunt();
                    end else begin
                        sv         = int'($signed(b));
                        wsum       = wsum + SUM_W'(sv * weight_at(widx));
                        widx       = widx + 1'b1;
                        left       = left - 1'b1;
                        r.out_byte = b;
                        r.is_type  = (phase == PH_TYPE);
                        phase      = PH_BODY;
                        owed_q = {owed_q, r};
                    end
                end
            endcase
        endfunction

        function void check_frame_output(logic [BYTE_W-1:0] data, logic last,
                                         logic [TUSER_W-1:0] user);
            t_result exp;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected transfer data=%h last=%b user=%b",
                         $time, data, last, user);
                errors++;
                return;
            end
            exp = owed_q.pop_front();
            if (data != exp.out_byte) begin
                $display("%0t: out_byte expected %h actual %h", $time, exp.out_byte, data);
                errors++;
            end
            if (user[0] != exp.is_type) begin
                $display("%0t: is_type expected %b actual %b", $time, exp.is_type, user[0]);
                errors++;
            end
            if (last != exp.frame_end) begin
                $display("%0t: frame_end expected %b actual %b", $time, exp.frame_end, last);
                errors++;
            end
            if (user[2:1] != exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, user[2:1]);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               s_tvalid   = 1'b0;
    logic [BYTE_W-1:0]  s_tdata    = '0;
    logic               m_tready   = 1'b1;
    logic               o_s_tready;
    logic               o_m_tvalid;
    logic [BYTE_W-1:0]  o_m_tdata;   // [7:0] out_byte
    logic               o_m_tlast;   // frame_end
    logic [TUSER_W-1:0] o_m_tuser;   // [0] is_type, [2:1] status

    deframe_scoreboard sb;
    int  bytes_sent = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    logic [BYTE_W-1:0] extremes [4] = '{8'h80, 8'h7F, 8'hFF, 8'h00};

    sync_length_checksum_deframer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 2);
        return $urandom_range(5, 30);
    endfunction

    // Sink side: random stalls unless in a calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            m_tready   <= 1'b0;
            stall_left <= pick_pause();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready)
                sb.check_frame_output(o_m_tdata, o_m_tlast, o_m_tuser);
            if (s_tvalid && o_s_tready)
                sb.note_rx_byte(s_tdata);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 2000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_calm ? 0 : ($urandom_range(0, 99) < 50 ? 0 : pick_pause());
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_sync();
        send_rx_byte(SYNC_S);
        send_rx_byte(SYNC_C);
        send_rx_byte(SYNC_R);
        send_rx_byte(SYNC_T);
    endtask

    // Sync word, length, body and check byte; a bad check is flipped by a nonzero mask.
    task automatic send_frame(input int len, input bit good, input bit cycle_extremes);
        logic signed [SUM_W-1:0] s;
        logic [BYTE_W-1:0]       b;
        logic [BYTE_W-1:0]       chk;
        s = '0;
        send_sync();
        send_rx_byte(8'(len));
        for (int i = 0; i < len - 1; i++) begin
            if (cycle_extremes)
                b = extremes[i % 4];
            else if ($urandom_range(0, 3) == 0)
                b = extremes[$urandom_range(0, 3)];
            else
                b = 8'($urandom);
            s = s + SUM_W'(int'($signed(b)) * deframe_scoreboard::weight_at(2'(i)));
            send_rx_byte(b);
        end
        chk = deframe_scoreboard::check_of(s);
        if (!good)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_rx_byte(chk);
    endtask

    initial begin
        int  kind;
        int  n;
        bit  drained;
        sb = new();
        drained = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: noise, overlapped sync, length one, bad lengths, extreme bytes.
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(SYNC_S);
        send_frame(1, 1'b1, 1'b0);
        send_sync();
        send_rx_byte(8'h00);
        send_sync();
        send_rx_byte(8'h80);
        send_frame(5, 1'b0, 1'b1);

        while (bytes_sent < 620) begin
            if ($urandom_range(0, 19) == 0) begin
                tx_calm = ~tx_calm;
                rx_calm = $urandom_range(0, 1);
            end
            if (!drained && bytes_sent >= 300) begin
                // Hold the source until the block has delivered everything.
                s_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.outstanding() != 0);
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                n = $urandom_range(1, 4);
                repeat (n) send_rx_byte(8'($urandom));
            end else if (kind < 13) begin
                // Broken sync word.
                send_rx_byte(SYNC_S);
                send_rx_byte(SYNC_C);
                if ($urandom_range(0, 1))
                    send_rx_byte(SYNC_R);
                send_rx_byte(8'($urandom));
            end else if (kind < 22) begin
                send_sync();
                send_rx_byte($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(128, 255)));
            end else if (kind < 24) begin
                send_frame(MAX_FRAME_LEN_DEF, $urandom_range(0, 3) != 0, 1'b0);
            end else begin
                send_frame($urandom_range(1, 12), $urandom_range(0, 3) != 0, 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
